/* design/mtks_pkg.sv */
// Shared types, character codes and lexer step functions for the markdown token streamer.
package mtks_pkg;

  localparam int NSLOT = 4;
  localparam int SAW = $clog2(NSLOT);
  localparam int SCW = $clog2(NSLOT + 1);
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = QAW + 1;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  typedef enum logic [3:0] {
    TK_TEXT    = 4'd0,
    TK_HEADER  = 4'd1,
    TK_BOLD    = 4'd2,
    TK_ITALIC  = 4'd3,
    TK_LINK    = 4'd4,
    TK_IMAGE   = 4'd5,
    TK_CODE    = 4'd6,
    TK_NEWLINE = 4'd7,
    TK_CRLF    = 4'd8,
    TK_EOF     = 4'd9
  } tok_t;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_HEADER  = 10'b0000000010,
    M_EMPH    = 10'b0000000100,
    M_BANG    = 10'b0000001000,
    M_LBODY   = 10'b0000010000,
    M_AFTERBR = 10'b0000100000,
    M_URL     = 10'b0001000000,
    M_CODE    = 10'b0010000000,
    M_CR      = 10'b0100000000,
    M_TEXT    = 10'b1000000000
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  marker;
    logic  image;
  } lex_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    tok_t       tok;
  } res_t;

  typedef struct packed {
    logic [SCW-1:0]        cnt;
    res_t [NSLOT-1:0]      res;
  } bundle_t;

  typedef struct packed {
    lex_state_t st;
    logic       done;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } pass_t;

  localparam lex_state_t LEX_RESET = '{mode: M_IDLE, marker: 1'b0, image: 1'b0};

  function automatic res_t mk_val(input logic [7:0] b);
    res_t r;
    r.kind = 1'b0;
    r.data = b;
    r.tok  = TK_TEXT;
    return r;
  endfunction

  function automatic res_t mk_close(input tok_t t);
    res_t r;
    r.kind = 1'b1;
    r.data = 8'h00;
    r.tok  = t;
    return r;
  endfunction

  function automatic tok_t link_tok(input logic image);
    return image ? TK_IMAGE : TK_LINK;
  endfunction

  // One lexer step on a byte; done low means the byte is handled again.
  function automatic pass_t lex_pass(input lex_state_t s, input logic [7:0] b);
    pass_t      p;
    logic [7:0] m;
    m      = s.marker ? CH_UNDER : CH_STAR;
    p.st   = s;
    p.done = 1'b1;
    p.n    = 2'd0;
    p.r0   = mk_val(8'h00);
    p.r1   = mk_val(8'h00);
    case (s.mode)
      M_HEADER: begin
        p.n = 2'd1;
        if (b == CH_HASH) begin
          p.r0 = mk_val(b);
        end else begin
          p.r0 = mk_close(TK_HEADER);
          p.st.mode = M_IDLE;
          p.st.image = 1'b0;
          p.done = 1'b0;
        end
      end
      M_EMPH: begin
        p.st.mode = M_IDLE;
        p.st.image = 1'b0;
        if (b == m) begin
          p.n = 2'd2;
          p.r0 = mk_val(b);
          p.r1 = mk_close(TK_BOLD);
        end else begin
          p.n = 2'd1;
          p.r0 = mk_close(TK_ITALIC);
          p.done = 1'b0;
        end
      end
      M_BANG: begin
        p.n = 2'd1;
        if (b == CH_LBRACK) begin
          p.r0 = mk_val(b);
          p.st.image = 1'b1;
          p.st.mode = M_LBODY;
        end else begin
          p.r0 = mk_val(CH_BANG);
          p.st.mode = M_TEXT;
          p.done = 1'b0;
        end
      end
      M_LBODY: begin
        p.n = 2'd1;
        p.r0 = mk_val(b);
        if (b == CH_RBRACK) begin
          p.st.mode = M_AFTERBR;
        end
      end
      M_AFTERBR: begin
        p.n = 2'd1;
        if (b == CH_LPAREN) begin
          p.r0 = mk_val(b);
          p.st.mode = M_URL;
        end else begin
          p.r0 = mk_close(link_tok(s.image));
          p.st.mode = M_IDLE;
          p.st.image = 1'b0;
          p.done = 1'b0;
        end
      end
      M_URL: begin
        p.n = 2'd1;
        p.r0 = mk_val(b);
        if (b == CH_RPAREN) begin
          p.n = 2'd2;
          p.r1 = mk_close(link_tok(s.image));
          p.st.mode = M_IDLE;
          p.st.image = 1'b0;
        end
      end
      M_CODE: begin
        p.n = 2'd1;
        if (b == CH_TICK) begin
          p.r0 = mk_close(TK_CODE);
          p.st.mode = M_IDLE;
          p.st.image = 1'b0;
        end else begin
          p.r0 = mk_val(b);
        end
      end
      M_CR: begin
        p.st.mode = M_IDLE;
        p.st.image = 1'b0;
        if (b == CH_LF) begin
          p.n = 2'd2;
          p.r0 = mk_val(b);
          p.r1 = mk_close(TK_CRLF);
        end else begin
          p.n = 2'd1;
          p.r0 = mk_close(TK_TEXT);
          p.done = 1'b0;
        end
      end
      M_TEXT: begin
        p.n = 2'd1;
        if (b inside {CH_LF, CH_CR, CH_STAR, CH_UNDER, CH_LBRACK, CH_TICK}) begin
          p.r0 = mk_close(TK_TEXT);
          p.st.mode = M_IDLE;
          p.st.image = 1'b0;
          p.done = 1'b0;
        end else begin
          p.r0 = mk_val(b);
        end
      end
      default: begin
        p.st.mode = M_IDLE;
        p.st.image = 1'b0;
        case (b) inside
          CH_SPACE, CH_TAB, CH_VT, CH_FF: begin
            p.n = 2'd0;
          end
          CH_HASH: begin
            p.n = 2'd1;
            p.r0 = mk_val(b);
            p.st.mode = M_HEADER;
          end
          CH_STAR, CH_UNDER: begin
            p.n = 2'd1;
            p.r0 = mk_val(b);
            p.st.marker = (b == CH_UNDER);
            p.st.mode = M_EMPH;
          end
          CH_LBRACK: begin
            p.n = 2'd1;
            p.r0 = mk_val(b);
            p.st.mode = M_LBODY;
          end
          CH_BANG: begin
            p.st.mode = M_BANG;
          end
          CH_TICK: begin
            p.st.mode = M_CODE;
          end
          CH_LF: begin
            p.n = 2'd2;
            p.r0 = mk_val(b);
            p.r1 = mk_close(TK_NEWLINE);
          end
          CH_CR: begin
            p.n = 2'd1;
            p.r0 = mk_val(b);
            p.st.mode = M_CR;
          end
          default: begin
            p.n = 2'd1;
            p.r0 = mk_val(b);
            p.st.mode = M_TEXT;
          end
        endcase
      end
    endcase
    return p;
  endfunction

  // Close any open token and append the end-of-file close.
  function automatic bundle_t lex_finish(input lex_state_t s);
    bundle_t  bd;
    res_t     eof;
    eof = mk_close(TK_EOF);
    bd.res = '0;
    bd.cnt = SCW'(2);
    bd.res[1] = eof;
    case (s.mode)
      M_HEADER:           bd.res[0] = mk_close(TK_HEADER);
      M_EMPH:             bd.res[0] = mk_close(TK_ITALIC);
      M_BANG: begin
        bd.cnt = SCW'(3);
        bd.res[0] = mk_val(CH_BANG);
        bd.res[1] = mk_close(TK_TEXT);
        bd.res[2] = eof;
      end
      M_LBODY:            bd.res[0] = mk_close(TK_TEXT);
      M_AFTERBR, M_URL:   bd.res[0] = mk_close(link_tok(s.image));
      M_CODE:             bd.res[0] = mk_close(TK_CODE);
      M_CR, M_TEXT:       bd.res[0] = mk_close(TK_TEXT);
      default: begin
        bd.cnt = SCW'(1);
        bd.res[0] = eof;
        bd.res[1] = mk_val(8'h00);
      end
    endcase
    return bd;
  endfunction

endpackage

/* design/mtks_front.sv */
// Front end: lexer state and classification of each transaction into a bundle of results.
module mtks_front
  import mtks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       q_full,
  input  logic       command,
  input  logic [7:0] in_byte,
  output logic       full,
  output logic       wr_en,
  output bundle_t    wr_data
);

  lex_state_t st;
  lex_state_t st_next;
  pass_t      p0;
  pass_t      p1;
  pass_t      p2;
  pass_t      ps [3];
  logic [2:0] act;
  bundle_t    bd;
  logic       accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    p0 = lex_pass(st, in_byte);
    p1 = lex_pass(p0.st, in_byte);
    p2 = lex_pass(p1.st, in_byte);
    ps[0] = p0;
    ps[1] = p1;
    ps[2] = p2;
    act = {!p0.done && !p1.done, !p0.done, 1'b1};
    if (command) begin
      bd = lex_finish(st);
      st_next = LEX_RESET;
    end else begin
      bd.cnt = '0;
      bd.res = '0;
      for (int i = 0; i < 3; i++) begin
        if (act[i]) begin
          if (ps[i].n != 2'd0) begin
            bd.res[bd.cnt[SAW-1:0]] = ps[i].r0;
            bd.cnt = bd.cnt + 1'b1;
          end
          if (ps[i].n == 2'd2) begin
            bd.res[bd.cnt[SAW-1:0]] = ps[i].r1;
            bd.cnt = bd.cnt + 1'b1;
          end
        end
      end
      st_next = p0.done ? p0.st : (p1.done ? p1.st : p2.st);
    end
  end

  assign wr_en   = accept && (bd.cnt != '0);
  assign wr_data = bd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LEX_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

/* design/mtks_queue.sv */
// Bundle queue between the front end and the result serialiser.
module mtks_queue
  import mtks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  bundle_t wr_data,
  input  logic    rd_en,
  output bundle_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam logic [QCW-1:0] QFULL = QCW'(QDEPTH);

  bundle_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full    = (count == QFULL);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/mtks_back.sv */
// Back end: serialise each bundle into single results through the output register.
module mtks_back
  import mtks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    rd_data,
  input  logic       q_empty,
  output logic       rd_en,
  input  logic       pop,
  output logic       empty,
  output logic       item_kind,
  output logic [7:0] out_byte,
  output logic [3:0] token_kind,
  output logic       run_end
);

  logic [SAW-1:0] idx;
  logic           out_valid;
  res_t           out_res;
  logic           out_last;
  logic           last;
  logic           load;

  assign last  = (SCW'(idx) == (rd_data.cnt - SCW'(1)));
  assign load  = !q_empty && (!out_valid || pop);
  assign rd_en = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= rd_data.res[idx];
      out_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= last ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty      = !out_valid;
  assign item_kind  = out_res.kind;
  assign out_byte   = out_res.data;
  assign token_kind = 4'(out_res.tok);
  assign run_end    = out_last;

endmodule

/* design/markdown_token_streamer_core.sv */
// Markdown token streamer: one transaction in per cycle while the four-bundle queue has room;
// each transaction yields zero to four results, and the back end delivers one result per cycle
// while pop is held, so a run of transactions with many results fills the queue and raises full.
// The first result of a transaction is written to the queue at the edge that accepts it and is
// then loaded into the output register when the output is free. The end command closes any
// open token and adds an EOF close.
module markdown_token_streamer_core
  import mtks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       command,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic       item_kind,
  output logic [7:0] out_byte,
  output logic [3:0] token_kind,
  output logic       run_end
);

  logic    q_full;
  logic    q_empty;
  logic    wr_en;
  logic    rd_en;
  bundle_t wr_data;
  bundle_t rd_data;

  mtks_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_full  (q_full),
    .command (command),
    .in_byte (in_byte),
    .full    (full),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  mtks_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  mtks_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_data    (rd_data),
    .q_empty    (q_empty),
    .rd_en      (rd_en),
    .pop        (pop),
    .empty      (empty),
    .item_kind  (item_kind),
    .out_byte   (out_byte),
    .token_kind (token_kind),
    .run_end    (run_end)
  );

endmodule

/* design/mtks_checker.sv */
// Port-level checks for the markdown token streamer, bound to the top level.
module mtks_checker
  import mtks_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       item_kind,
  input logic [7:0] out_byte,
  input logic [3:0] token_kind,
  input logic       run_end
);

  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(item_kind) && $stable(out_byte)
                          && $stable(token_kind) && $stable(run_end)))
    else $error("result changed while stalled");

  a_value_tok : assert property (@(posedge clk) disable iff (rst)
    (!empty && !item_kind) |-> (token_kind == TK_TEXT))
    else $error("value character carries a token kind");

  a_close_byte : assert property (@(posedge clk) disable iff (rst)
    (!empty && item_kind) |-> (out_byte == 8'h00 && token_kind <= TK_EOF))
    else $error("malformed close transaction");

  a_eof_last : assert property (@(posedge clk) disable iff (rst)
    (!empty && item_kind && token_kind == TK_EOF) |-> run_end)
    else $error("EOF close not last of its run");

endmodule

bind markdown_token_streamer_core mtks_checker u_mtks_checker (.*);

/* test/markdown_token_streamer_core_tb.sv */
`timescale 1ns / 100ps
// Testbench for the markdown token streamer: directed table, random markdown, token predictor.
module markdown_token_streamer_core_tb
  import mtks_pkg::*;
();

  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_END    = 1'b1;
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 220;
  localparam int N_DIRECTED     = 28;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    tok_t       tok;
    logic       last;
  } tok_item_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
    logic [1:0] ntyped;
    tok_item_t  t0;
    tok_item_t  t1;
  } stim_row_t;

  localparam tok_item_t NO_ITEM = '0;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_END,  8'hA5,     2'd1, '{KIND_CLOSE, 8'h00, TK_EOF, 1'b1}, NO_ITEM},
    '{CMD_BYTE, 8'h00,     2'd1, '{KIND_CHAR, 8'h00, TK_TEXT, 1'b1}, NO_ITEM},
    '{CMD_BYTE, 8'hFF,     2'd1, '{KIND_CHAR, 8'hFF, TK_TEXT, 1'b1}, NO_ITEM},
    '{CMD_BYTE, CH_STAR,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_STAR,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_UNDER,  2'd0, NO_ITEM, NO_ITEM},
    '{CMD_END,  8'h5A,     2'd2, '{KIND_CLOSE, 8'h00, TK_ITALIC, 1'b0},
                                 '{KIND_CLOSE, 8'h00, TK_EOF, 1'b1}},
    '{CMD_BYTE, CH_CR,     2'd1, '{KIND_CHAR, CH_CR, TK_TEXT, 1'b1}, NO_ITEM},
    '{CMD_BYTE, 8'h78,     2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_LF,     2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_HASH,   2'd1, '{KIND_CHAR, CH_HASH, TK_TEXT, 1'b1}, NO_ITEM},
    '{CMD_BYTE, CH_BANG,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_LBRACK, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_RBRACK, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_LPAREN, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_RPAREN, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_BANG,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_LF,     2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_TICK,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_TAB,    2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_TICK,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_LBRACK, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_RBRACK, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, 8'h7A,     2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_LBRACK, 2'd0, NO_ITEM, NO_ITEM},
    '{CMD_END,  8'h00,     2'd0, NO_ITEM, NO_ITEM},
    '{CMD_BYTE, CH_BANG,   2'd0, NO_ITEM, NO_ITEM},
    '{CMD_END,  8'hFF,     2'd0, NO_ITEM, NO_ITEM}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       command = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic       item_kind;
  logic [7:0] out_byte;
  logic [3:0] token_kind;
  logic       run_end;

  mode_t      lx_mode = M_IDLE;
  logic       lx_under = 1'b0;
  logic       lx_image = 1'b0;
  tok_item_t  step_items[$];
  tok_item_t  tokens_due[$];
  stim_row_t  markdown_q[$];
  int         fail_count = 0;
  int         results_seen = 0;
  int         quiet_cycles = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;
  bit         long_hold_done = 1'b0;

  markdown_token_streamer_core u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command), .in_byte(in_byte),
    .empty(empty), .pop(pop), .item_kind(item_kind), .out_byte(out_byte),
    .token_kind(token_kind), .run_end(run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void emit_char(input logic [7:0] b);
    tok_item_t t;
    t.kind = KIND_CHAR;
    t.data = b;
    t.tok  = TK_TEXT;
    t.last = 1'b0;
    step_items.insert(step_items.size(), t);
  endfunction

  function automatic void emit_close(input tok_t tk);
    tok_item_t t;
    t.kind = KIND_CLOSE;
    t.data = 8'h00;
    t.tok  = tk;
    t.last = 1'b0;
    step_items.insert(step_items.size(), t);
    lx_mode  = M_IDLE;
    lx_image = 1'b0;
  endfunction

  function automatic tok_t link_or_image();
    return lx_image ? TK_IMAGE : TK_LINK;
  endfunction

  function automatic void start_token(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_VT, CH_FF: ;
      CH_HASH: begin
        emit_char(b);
        lx_mode = M_HEADER;
      end
      CH_STAR, CH_UNDER: begin
        emit_char(b);
        lx_under = (b == CH_UNDER);
        lx_mode = M_EMPH;
      end
      CH_LBRACK: begin
        emit_char(b);
        lx_image = 1'b0;
        lx_mode = M_LBODY;
      end
      CH_BANG: lx_mode = M_BANG;
      CH_TICK: lx_mode = M_CODE;
      CH_LF: begin
        emit_char(b);
        emit_close(TK_NEWLINE);
      end
      CH_CR: begin
        emit_char(b);
        lx_mode = M_CR;
      end
      default: begin
        emit_char(b);
        lx_mode = M_TEXT;
      end
    endcase
  endfunction

  // Returns 0 when the byte must be lexed again in the new mode, as when it ends a token.
  function automatic bit lex_byte(input logic [7:0] b);
    logic [7:0] mark;
    mark = lx_under ? CH_UNDER : CH_STAR;
    case (lx_mode)
      M_HEADER: begin
        if (b == CH_HASH) begin
          emit_char(b);
          return 1'b1;
        end
        emit_close(TK_HEADER);
        return 1'b0;
      end
      M_EMPH: begin
        if (b == mark) begin
          emit_char(b);
          emit_close(TK_BOLD);
          return 1'b1;
        end
        emit_close(TK_ITALIC);
        return 1'b0;
      end
      M_BANG: begin
        if (b == CH_LBRACK) begin
          emit_char(b);
          lx_image = 1'b1;
          lx_mode = M_LBODY;
          return 1'b1;
        end
        emit_char(CH_BANG);
        lx_mode = M_TEXT;
        return 1'b0;
      end
      M_LBODY: begin
        emit_char(b);
        if (b == CH_RBRACK) lx_mode = M_AFTERBR;
        return 1'b1;
      end
      M_AFTERBR: begin
        if (b == CH_LPAREN) begin
          emit_char(b);
          lx_mode = M_URL;
          return 1'b1;
        end
        emit_close(link_or_image());
        return 1'b0;
      end
      M_URL: begin
        emit_char(b);
        if (b == CH_RPAREN) emit_close(link_or_image());
        return 1'b1;
      end
      M_CODE: begin
        if (b == CH_TICK) emit_close(TK_CODE);
        else emit_char(b);
        return 1'b1;
      end
      M_CR: begin
        if (b == CH_LF) begin
          emit_char(b);
          emit_close(TK_CRLF);
          return 1'b1;
        end
        emit_close(TK_TEXT);
        return 1'b0;
      end
      M_TEXT: begin
        if (b == CH_LF || b == CH_CR || b == CH_STAR || b == CH_UNDER ||
            b == CH_LBRACK || b == CH_TICK) begin
          emit_close(TK_TEXT);
          return 1'b0;
        end
        emit_char(b);
        return 1'b1;
      end
      default: begin
        lx_mode = M_IDLE;
        lx_image = 1'b0;
        start_token(b);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void finish_input();
    case (lx_mode)
      M_HEADER: emit_close(TK_HEADER);
      M_EMPH: emit_close(TK_ITALIC);
      M_BANG: begin
        emit_char(CH_BANG);
        emit_close(TK_TEXT);
      end
      M_LBODY: emit_close(TK_TEXT);
      M_AFTERBR, M_URL: emit_close(link_or_image());
      M_CODE: emit_close(TK_CODE);
      M_CR, M_TEXT: emit_close(TK_TEXT);
      default: ;
    endcase
    emit_close(TK_EOF);
    lx_under = 1'b0;
  endfunction

  function automatic void predict_tokens(input logic cmd, input logic [7:0] b);
    int pass_no;
    step_items.delete();
    if (cmd == CMD_END) begin
      finish_input();
    end else begin
      for (pass_no = 0; pass_no < 3; pass_no++) begin
        if (lex_byte(b)) break;
      end
    end
    if (step_items.size() != 0) step_items[step_items.size() - 1].last = 1'b1;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_row(input logic cmd, input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.cmd = cmd;
    r.b = b;
    markdown_q.insert(markdown_q.size(), r);
  endfunction

  function automatic void add_word();
    int n;
    int r;
    n = $urandom_range(1, 6);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) add_row(CMD_BYTE, 8'($urandom_range(128, 255)));
      else if (r == 1) add_row(CMD_BYTE, 8'($urandom_range(8'h30, 8'h39)));
      else add_row(CMD_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
    end
  endfunction

  function automatic void add_link();
    add_row(CMD_BYTE, CH_LBRACK);
    add_word();
    add_row(CMD_BYTE, CH_RBRACK);
    if ($urandom_range(0, 3) != 0) begin
      add_row(CMD_BYTE, CH_LPAREN);
      add_word();
      add_row(CMD_BYTE, CH_RPAREN);
    end
  endfunction

  // Append one markdown fragment; mostly well formed, some noise and broken input.
  task automatic add_fragment();
    int r;
    int n;
    logic [7:0] mk;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    mk = $urandom_range(0, 1) ? CH_UNDER : CH_STAR;
    if (r < 20) begin
      add_word();
      add_row(CMD_BYTE, CH_SPACE);
    end else if (r < 28) begin
      n = $urandom_range(1, 4);
      repeat (n) add_row(CMD_BYTE, CH_HASH);
      if ($urandom_range(0, 1)) add_row(CMD_BYTE, CH_SPACE);
      add_word();
    end else if (r < 38) begin
      add_row(CMD_BYTE, mk);
      add_row(CMD_BYTE, mk);
      add_word();
      add_row(CMD_BYTE, mk);
      add_row(CMD_BYTE, mk);
    end else if (r < 46) begin
      add_row(CMD_BYTE, mk);
      add_word();
      add_row(CMD_BYTE, mk);
    end else if (r < 56) begin
      add_link();
    end else if (r < 63) begin
      add_row(CMD_BYTE, CH_BANG);
      add_link();
    end else if (r < 70) begin
      add_row(CMD_BYTE, CH_TICK);
      n = $urandom_range(0, 5);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        add_row(CMD_BYTE, (b == CH_TICK) ? 8'h41 : b);
      end
      add_row(CMD_BYTE, CH_TICK);
    end else if (r < 76) begin
      if ($urandom_range(0, 1)) add_row(CMD_BYTE, CH_CR);
      add_row(CMD_BYTE, CH_LF);
    end else if (r < 80) begin
      add_row(CMD_BYTE, CH_CR);
      add_word();
    end else if (r < 84) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: add_row(CMD_BYTE, CH_SPACE);
          1: add_row(CMD_BYTE, CH_TAB);
          2: add_row(CMD_BYTE, CH_VT);
          default: add_row(CMD_BYTE, CH_FF);
        endcase
      end
    end else if (r < 87) begin
      add_row(CMD_BYTE, CH_BANG);
      add_word();
    end else if (r < 93) begin
      n = $urandom_range(1, 4);
      repeat (n) add_row(CMD_BYTE, 8'($urandom_range(0, 255)));
    end else if (r < 96) begin
      case ($urandom_range(0, 4))
        0: begin
          add_row(CMD_BYTE, CH_LBRACK);
          add_word();
        end
        1: begin
          add_row(CMD_BYTE, CH_BANG);
          add_row(CMD_BYTE, CH_LBRACK);
          add_word();
          add_row(CMD_BYTE, CH_RBRACK);
          add_row(CMD_BYTE, CH_LPAREN);
          add_word();
        end
        2: add_row(CMD_BYTE, mk);
        3: begin
          add_row(CMD_BYTE, CH_TICK);
          add_word();
        end
        default: add_row(CMD_BYTE, CH_BANG);
      endcase
      add_row(CMD_END, 8'($urandom_range(0, 255)));
    end else begin
      add_row(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_result();
    tok_item_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h token %0d last %0d",
                                item_kind, out_byte, token_kind, run_end));
      return;
    end
    want = tokens_due.pop_front();
    if (item_kind !== want.kind)
      report_mismatch($sformatf("item_kind got %0d want %0d", item_kind, want.kind));
    if (out_byte !== want.data)
      report_mismatch($sformatf("out_byte got %02h want %02h", out_byte, want.data));
    if (token_kind !== 4'(want.tok))
      report_mismatch($sformatf("token_kind got %0d want %0d", token_kind, want.tok));
    if (run_end !== want.last)
      report_mismatch($sformatf("run_end got %0d want %0d", run_end, want.last));
  endtask

  task automatic send_transaction(input stim_row_t row);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    command <= row.cmd;
    in_byte <= row.b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_tokens(row.cmd, row.b);
    if (row.ntyped == 2'd0) begin
      foreach (step_items[i]) tokens_due.insert(tokens_due.size(), step_items[i]);
    end else begin
      tokens_due.insert(tokens_due.size(), row.t0);
      if (row.ntyped == 2'd2) tokens_due.insert(tokens_due.size(), row.t1);
    end
  endtask

  initial begin : result_side
    int stall;
    while (rst) @(posedge clk);
    pop <= 1'b1;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        check_result();
        results_seen++;
        if (results_seen % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      end
      if (results_seen >= 80 && !long_hold_done) begin
        long_hold_done = 1'b1;
        pop <= 1'b0;
        repeat (100) @(posedge clk);
        pop <= 1'b1;
      end else begin
        stall = pick_gap(recv_calm);
        if (stall > 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : byte_side
    stim_row_t row;
    mode_t     mode_before;
    int        fed;
    bit        paused;
    fed = 0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_transaction(DIRECTED[i]);
    while (fed < RANDOM_ITEMS) begin
      if (markdown_q.size() == 0) begin
        add_fragment();
        send_calm = ($urandom_range(0, 4) == 0);
      end
      row = markdown_q.pop_front();
      mode_before = lx_mode;
      send_transaction(row);
      if (step_items.size() != 0 || lx_mode != mode_before) fed++;
      if (!paused && fed >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        push <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0) @(posedge clk);
      end
    end
    push <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
